[hdl/u8d_pkg.sv]
// Shared types and constants for the UTF-8 to 16-bit code unit decoder.
// Used by the interfaces, the decoder core, the output skid stage and the top.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned CfgDataW      = 16;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned UnitW         = 16;

  localparam logic [CfgIdxW-1:0] RegLimitEnable = 1'd0;
  localparam logic [CfgIdxW-1:0] RegOutputLimit = 1'd1;

  localparam logic [UnitW-1:0] OutputLimitRst = 16'hFFFF;

  // byte classes
  localparam logic [7:0] AsciiEnd    = 8'h80;
  localparam logic [7:0] Lead2Min    = 8'hC2;
  localparam logic [7:0] Lead3Min    = 8'hE0;
  localparam logic [7:0] Lead4Min    = 8'hF0;
  localparam logic [1:0] ContTag     = 2'b10;

  typedef enum logic [1:0] {
    ST_UNIT    = 2'd0,
    ST_END     = 2'd1,
    ST_ILLEGAL = 2'd2,
    ST_LIMIT   = 2'd3
  } status_e;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    status_e          status;
    logic [UnitW-1:0] unit_total;
  } result_t;

  typedef struct packed {
    logic             limit_enable;
    logic [UnitW-1:0] output_limit;
  } cfg_t;

endpackage : u8d_pkg

`default_nettype wire

[hdl/u8d_if.sv]
// Valid/ready stream interfaces: UTF-8 byte input and code unit output.
// Depends on u8d_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface : u8d_byte_if

interface u8d_unit_if;
  logic                        valid;
  logic                        ready;
  logic [u8d_pkg::UnitW-1:0]   code_unit;
  logic [1:0]                  status;
  logic [u8d_pkg::UnitW-1:0]   unit_total;

  modport source (output valid, output code_unit, output status, output unit_total,
                  input ready);
  modport sink   (input valid, input code_unit, input status, input unit_total,
                  output ready);
endinterface : u8d_unit_if

`default_nettype wire

[hdl/utf8_stream_decoder_bmp_top.sv]
// UTF-8 to 16-bit code unit decoder (BMP only), top level.
// Channels: byte_in_i takes one UTF-8 byte per transfer with a restart flag;
// unit_out_o gives at most one result per byte: a code unit, end of string,
// illegal sequence or limit reached, with the running unit count.
// Configuration: cfg_we_i writes limit_enable (index 0) or output_limit
// (index 1) from cfg_wdata_i; write only while no bytes are in flight.
// Output: a byte that completes a character or ends decoding shows its
// result through the registered output stage. Lead and middle bytes give no result.
// Throughput: one byte per cycle while the skid entry is empty, set by the
// combinational step logic that updates the sequence state and counter.
// Stall: results sit in an output register backed by one skid entry; byte
// input stays ready until the skid entry is occupied, then waits for the
// receiver to take a result.
// After end of string, an error or the limit, bytes are consumed silently
// until one arrives with restart set.
// Reset: pending sequence, count and halt clear; limit_enable resets to 0
// and output_limit to 65535; the output stage empties.
// Depends on u8d_pkg, u8d_if, u8d_core and u8d_skid.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_bmp_top #(
  parameter int unsigned COUNT_WIDTH = u8d_pkg::CountWidthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [u8d_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [u8d_pkg::CfgDataW-1:0]   cfg_wdata_i,
  u8d_byte_if.sink                            byte_in_i,
  u8d_unit_if.source                          unit_out_o
);

  u8d_pkg::cfg_t    cfg_q;
  logic             accept;
  logic             skid_ready;
  logic             res_valid;
  u8d_pkg::result_t res;
  logic             out_valid;
  u8d_pkg::result_t out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_enable <= 1'b0;
      cfg_q.output_limit <= u8d_pkg::OutputLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        u8d_pkg::RegLimitEnable: cfg_q.limit_enable <= cfg_wdata_i[0];
        u8d_pkg::RegOutputLimit: cfg_q.output_limit <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign byte_in_i.ready = skid_ready;
  assign accept          = byte_in_i.valid && skid_ready;

  u8d_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (byte_in_i.data_byte),
    .restart_i   (byte_in_i.restart),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  u8d_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (skid_ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_ready_i (unit_out_o.ready)
  );

  assign unit_out_o.valid      = out_valid;
  assign unit_out_o.code_unit  = out_data.code_unit;
  assign unit_out_o.status     = out_data.status;
  assign unit_out_o.unit_total = out_data.unit_total;

  // the skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !byte_in_i.ready |-> unit_out_o.valid)
    else $error("input stalled with no result waiting");

  a_stop_has_no_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status != u8d_pkg::ST_UNIT) |-> (res.code_unit == '0))
    else $error("non-unit result carries a code unit");

  a_end_from_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status == u8d_pkg::ST_END) |-> (byte_in_i.data_byte == 8'h00))
    else $error("end of string without a NUL byte");

  a_result_needs_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> accept)
    else $error("result produced without a byte transfer");

endmodule : utf8_stream_decoder_bmp_top

`default_nettype wire

[hdl/u8d_core.sv]
// Decoder state and per-byte step logic: sequence tracking, unit count, halt.
// Depends on u8d_pkg for the result type and byte class constants.
`timescale 1ns / 1ps
`default_nettype none

module u8d_core #(
  parameter int unsigned COUNT_WIDTH = u8d_pkg::CountWidthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             restart_i,
  input  wire u8d_pkg::cfg_t    cfg_i,
  output logic                  res_valid_o,
  output u8d_pkg::result_t      res_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > u8d_pkg::UnitW) ? COUNT_WIDTH
                                                                  : u8d_pkg::UnitW;

  logic [1:0]                pend_q, pend_d;
  logic [u8d_pkg::UnitW-1:0] part_q, part_d;
  logic [COUNT_WIDTH-1:0]    cnt_q, cnt_d;
  logic                      halt_q, halt_d;

  logic [1:0]                pend;
  logic [u8d_pkg::UnitW-1:0] part, part_next;
  logic [COUNT_WIDTH-1:0]    cnt, cnt_inc;
  logic                      halt;
  logic [CmpW-1:0]           cnt_ext, cnt_inc_ext, lim_ext;
  logic                      emit;
  u8d_pkg::result_t          res;

  // restart clears everything before the byte is looked at
  assign pend = restart_i ? 2'd0 : pend_q;
  assign part = restart_i ? '0 : part_q;
  assign cnt  = restart_i ? '0 : cnt_q;
  assign halt = restart_i ? 1'b0 : halt_q;

  assign cnt_inc     = cnt + COUNT_WIDTH'(1);
  assign cnt_ext     = CmpW'(cnt);
  assign cnt_inc_ext = CmpW'(cnt_inc);
  assign lim_ext     = CmpW'(cfg_i.output_limit);
  assign part_next   = {part[u8d_pkg::UnitW-7:0], data_byte_i[5:0]};

  always_comb begin
    pend_d         = pend;
    part_d         = part;
    cnt_d          = cnt;
    halt_d         = halt;
    emit           = 1'b0;
    res.code_unit  = '0;
    res.status     = u8d_pkg::ST_UNIT;
    res.unit_total = cnt_ext[u8d_pkg::UnitW-1:0];
    if (!halt) begin
      if (pend != 2'd0) begin
        if (data_byte_i[7:6] != u8d_pkg::ContTag) begin
          pend_d     = 2'd0;
          part_d     = '0;
          halt_d     = 1'b1;
          emit       = 1'b1;
          res.status = u8d_pkg::ST_ILLEGAL;
        end else if (pend == 2'd1) begin
          pend_d         = 2'd0;
          part_d         = '0;
          cnt_d          = cnt_inc;
          emit           = 1'b1;
          res.code_unit  = part_next;
          res.unit_total = cnt_inc_ext[u8d_pkg::UnitW-1:0];
        end else begin
          pend_d = pend - 2'd1;
          part_d = part_next;
        end
      end else if (data_byte_i == 8'h00) begin
        halt_d     = 1'b1;
        emit       = 1'b1;
        res.status = u8d_pkg::ST_END;
      end else if (cfg_i.limit_enable && (cnt_ext >= lim_ext)) begin
        // drop the byte and stop
        halt_d     = 1'b1;
        emit       = 1'b1;
        res.status = u8d_pkg::ST_LIMIT;
      end else if (data_byte_i < u8d_pkg::AsciiEnd) begin
        cnt_d          = cnt_inc;
        emit           = 1'b1;
        res.code_unit  = {8'h00, data_byte_i};
        res.unit_total = cnt_inc_ext[u8d_pkg::UnitW-1:0];
      end else if (data_byte_i < u8d_pkg::Lead2Min || data_byte_i >= u8d_pkg::Lead4Min) begin
        halt_d     = 1'b1;
        emit       = 1'b1;
        res.status = u8d_pkg::ST_ILLEGAL;
      end else if (data_byte_i < u8d_pkg::Lead3Min) begin
        pend_d = 2'd1;
        part_d = {11'd0, data_byte_i[4:0]};
      end else begin
        pend_d = 2'd2;
        part_d = {12'd0, data_byte_i[3:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      part_q <= '0;
      cnt_q  <= '0;
      halt_q <= 1'b0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      part_q <= part_d;
      cnt_q  <= cnt_d;
      halt_q <= halt_d;
    end
  end

  assign res_valid_o = accept_i && emit;
  assign res_o       = res;

endmodule : u8d_core

`default_nettype wire

[hdl/u8d_skid.sv]
// Output register plus one skid entry for decoded results.
// Depends on u8d_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module u8d_skid (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire u8d_pkg::result_t  in_data_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output u8d_pkg::result_t       out_data_o,
  input  wire logic              out_ready_i
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  u8d_pkg::result_t out_q, out_d;
  u8d_pkg::result_t skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        // drain the skid entry first; no transfer came in this cycle
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_valid_i;
        out_d       = in_data_i;
      end
    end else if (in_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : u8d_skid

`default_nettype wire
